// ----- src/ffba_pkg.sv -----
// Shared types, constants and codes of the first-fit block allocator.
// Used by every module in src; depends on nothing.
package ffba_pkg;

	localparam int NumBlocksDef  = 1024;
	localparam int DescBitsDef   = 8;
	localparam int BlockBytesDef = 8;

	localparam int OpW   = 2;
	localparam int DescW = 8;
	localparam int SizeW = 14;
	localparam int StW   = 2;
	localparam int BlkW  = 10;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_GET    = 2'd1,
		OP_DELETE = 2'd2,
		OP_DEFRAG = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_NO_SPACE  = 2'd2,
		ST_BAD       = 2'd3
	} status_t;

	typedef struct packed {
		logic [OpW-1:0]   operation;
		logic [DescW-1:0] descriptor;
		logic [SizeW-1:0] size_bytes;
	} req_t;

	typedef struct packed {
		logic [StW-1:0]  status;
		logic [BlkW-1:0] start_block;
		logic [BlkW-1:0] end_block;
	} rsp_t;

	// Back-end state machine
	typedef enum logic [3:0] {
		BS_IDLE,
		BS_CLEAR,
		BS_ADD,
		BS_ADD_FILL,
		BS_FIND,
		BS_FIND_RUN,
		BS_FREE,
		BS_DEF,
		BS_DEF_ZERO,
		BS_DONE
	} bstate_t;

endpackage

// ----- src/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator.
// Depends on ffba_pkg, ffba_front and ffba_back.
//
// Requests are taken at a rising edge where start is high and busy low; each
// answer is on rsp for exactly one cycle with done high and must be taken in
// that cycle, since the block cannot be held off. After reset the map is
// cleared, busy high throughout. The map is walked one block a cycle
// with registered read data. An add or delete that succeeds then writes
// its run; defragment reads every block, packing the used ones to the
// front, then zeroes the tail. Malformed requests and oversize adds are
// answered without walking the map. busy falls in the cycle after the
// answer.
module first_fit_block_allocator #(
	parameter int NUM_BLOCKS  = ffba_pkg::NumBlocksDef,
	parameter int DESC_BITS   = ffba_pkg::DescBitsDef,
	parameter int BLOCK_BYTES = ffba_pkg::BlockBytesDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ffba_pkg::req_t req,
	output logic           done,
	output ffba_pkg::rsp_t rsp
);

	localparam int CntW = $clog2(NUM_BLOCKS + 1);

	logic                 take, cmd_valid, cmd_bad, cmd_big, idle;
	ffba_pkg::op_t        cmd_op;
	logic [DESC_BITS-1:0] cmd_desc;
	logic [CntW-1:0]      cmd_need;

	// Accept only when the back end is free
	assign busy = !idle;
	assign take = start && idle;

	ffba_front #(.NUM_BLOCKS(NUM_BLOCKS), .DESC_BITS(DESC_BITS),
		.BLOCK_BYTES(BLOCK_BYTES), .CNT_W(CntW)) u_front (
		.clk, .arst_n, .take, .req, .cmd_valid, .cmd_op, .cmd_desc,
		.cmd_need, .cmd_bad, .cmd_big
	);

	ffba_back #(.NUM_BLOCKS(NUM_BLOCKS), .DESC_BITS(DESC_BITS),
		.CNT_W(CntW)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_op, .cmd_desc, .cmd_need,
		.cmd_bad, .cmd_big, .idle, .done, .rsp
	);

endmodule

// ----- src/ffba_front.sv -----
// Front end of the allocator: accepts requests, masks and classifies them,
// and flags malformed and oversize ones for the back end. Depends on ffba_pkg.
module ffba_front #(
	parameter int NUM_BLOCKS  = ffba_pkg::NumBlocksDef,
	parameter int DESC_BITS   = ffba_pkg::DescBitsDef,
	parameter int BLOCK_BYTES = ffba_pkg::BlockBytesDef,
	parameter int CNT_W       = $clog2(NUM_BLOCKS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  ffba_pkg::req_t      req,
	output logic                cmd_valid,
	output ffba_pkg::op_t       cmd_op,
	output logic [DESC_BITS-1:0] cmd_desc,
	output logic [CNT_W-1:0]    cmd_need,
	output logic                cmd_bad,
	output logic                cmd_big
);

	localparam int NeedFullW = ffba_pkg::SizeW + 1;

	logic [DESC_BITS-1:0] desc_m;
	logic [NeedFullW-1:0] need_full;
	ffba_pkg::op_t        op_c;

	// Classify the incoming request
	always_comb begin
		op_c      = ffba_pkg::op_t'(req.operation);
		desc_m    = DESC_BITS'(req.descriptor);
		need_full = (NeedFullW'(req.size_bytes) + NeedFullW'(BLOCK_BYTES - 1))
		            / NeedFullW'(BLOCK_BYTES);
	end

	// Hold the classified command for the back end (queue of one)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			cmd_valid <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_op   <= op_c;
			cmd_desc <= desc_m;
			cmd_big  <= need_full > NeedFullW'(NUM_BLOCKS);
			cmd_need <= CNT_W'(need_full);
			cmd_bad  <= (op_c != ffba_pkg::OP_DEFRAG) &&
			            ((desc_m == '0) ||
			             (op_c == ffba_pkg::OP_ADD && req.size_bytes == '0));
		end
	end

endmodule

// ----- src/ffba_back.sv -----
// Back end of the allocator: owns the block map memory and walks it one
// block a cycle for add, get, delete and defragment. Depends on ffba_pkg.
module ffba_back #(
	parameter int NUM_BLOCKS = ffba_pkg::NumBlocksDef,
	parameter int DESC_BITS  = ffba_pkg::DescBitsDef,
	parameter int CNT_W      = $clog2(NUM_BLOCKS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  ffba_pkg::op_t        cmd_op,
	input  logic [DESC_BITS-1:0] cmd_desc,
	input  logic [CNT_W-1:0]     cmd_need,
	input  logic                 cmd_bad,
	input  logic                 cmd_big,
	output logic                 idle,
	output logic                 done,
	output ffba_pkg::rsp_t       rsp
);

	localparam int AW = $clog2(NUM_BLOCKS);

	logic [DESC_BITS-1:0] mem [NUM_BLOCKS];

	ffba_pkg::bstate_t state_q, state_d;
	ffba_pkg::op_t     op_q;
	logic [DESC_BITS-1:0] desc_q;
	logic [CNT_W-1:0]  need_q, run_q, rd_q, wr_q;
	logic [AW-1:0]     first_q, last_q;
	logic [ffba_pkg::StW-1:0] st_q;

	// rd_q issues one read address a cycle; its data is registered and returns in the next cycle
	logic [DESC_BITS-1:0] rdata_s1;
	logic [AW-1:0]        addr_s1;
	logic                 vld_s1;
	logic                 rd_end, scan, scan_end;
	logic [AW-1:0]        ra;

	assign ra       = rd_q[AW-1:0];
	assign rd_end   = rd_q == CNT_W'(NUM_BLOCKS);
	assign scan     = state_q == ffba_pkg::BS_ADD || state_q == ffba_pkg::BS_FIND ||
	                  state_q == ffba_pkg::BS_FIND_RUN || state_q == ffba_pkg::BS_DEF;
	assign scan_end = rd_end && !vld_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::BS_IDLE: begin
				if (cmd_valid) begin
					if (cmd_op == ffba_pkg::OP_DEFRAG)   state_d = ffba_pkg::BS_DEF;
					else if (cmd_bad || (cmd_op == ffba_pkg::OP_ADD && cmd_big))
						state_d = ffba_pkg::BS_DONE;
					else if (cmd_op == ffba_pkg::OP_ADD) state_d = ffba_pkg::BS_ADD;
					else                                  state_d = ffba_pkg::BS_FIND;
				end
			end
			ffba_pkg::BS_CLEAR:
				if (rd_q == CNT_W'(NUM_BLOCKS - 1)) state_d = ffba_pkg::BS_IDLE;
			ffba_pkg::BS_ADD: begin
				if (scan_end) state_d = ffba_pkg::BS_DONE;
				else if (vld_s1 && rdata_s1 == '0 && run_q + 1'b1 == need_q)
					state_d = ffba_pkg::BS_ADD_FILL;
			end
			ffba_pkg::BS_ADD_FILL:
				if (wr_q == CNT_W'(last_q)) state_d = ffba_pkg::BS_DONE;
			ffba_pkg::BS_FIND: begin
				if (scan_end) state_d = ffba_pkg::BS_DONE;
				else if (vld_s1 && rdata_s1 == desc_q) state_d = ffba_pkg::BS_FIND_RUN;
			end
			ffba_pkg::BS_FIND_RUN: begin
				if (!vld_s1 || rdata_s1 != desc_q)
					state_d = (op_q == ffba_pkg::OP_DELETE) ? ffba_pkg::BS_FREE
					                                        : ffba_pkg::BS_DONE;
			end
			ffba_pkg::BS_FREE:
				if (wr_q == CNT_W'(last_q)) state_d = ffba_pkg::BS_DONE;
			ffba_pkg::BS_DEF:
				if (scan_end) state_d = ffba_pkg::BS_DEF_ZERO;
			ffba_pkg::BS_DEF_ZERO:
				if (wr_q == CNT_W'(NUM_BLOCKS)) state_d = ffba_pkg::BS_DONE;
			ffba_pkg::BS_DONE: state_d = ffba_pkg::BS_IDLE;
			default: state_d = ffba_pkg::BS_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		idle = state_q == ffba_pkg::BS_IDLE && !cmd_valid;
		done = state_q == ffba_pkg::BS_DONE;
		rsp.status      = st_q;
		rsp.start_block = (st_q == ffba_pkg::ST_OK) ? ffba_pkg::BlkW'(first_q) : '0;
		rsp.end_block   = (st_q == ffba_pkg::ST_OK) ? ffba_pkg::BlkW'(last_q)  : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::BS_CLEAR;
			rd_q    <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan && !rd_end;
			case (state_q)
				ffba_pkg::BS_CLEAR: rd_q <= rd_q + 1'b1;
				ffba_pkg::BS_IDLE:  rd_q <= '0;
				ffba_pkg::BS_ADD, ffba_pkg::BS_FIND, ffba_pkg::BS_FIND_RUN,
				ffba_pkg::BS_DEF:
					if (!rd_end) rd_q <= rd_q + 1'b1;
				default: rd_q <= rd_q;
			endcase
		end
	end

	// Registered map read
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[ra];
		addr_s1  <= ra;
	end

	// Datapath registers: request copy, run tracking, result
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::BS_IDLE: begin
				op_q   <= cmd_op;
				desc_q <= cmd_desc;
				need_q <= cmd_need;
				run_q  <= '0;
				wr_q   <= '0;
				first_q <= '0;
				last_q  <= '0;
				if (cmd_op == ffba_pkg::OP_DEFRAG) st_q <= ffba_pkg::ST_OK;
				else if (cmd_bad)                  st_q <= ffba_pkg::ST_BAD;
				else                               st_q <= ffba_pkg::ST_NO_SPACE;
			end
			ffba_pkg::BS_ADD: begin
				if (vld_s1) begin
					if (rdata_s1 == '0) begin
						if (run_q == '0) first_q <= addr_s1;
						run_q <= run_q + 1'b1;
						if (run_q + 1'b1 == need_q) begin
							last_q <= addr_s1;
							st_q   <= ffba_pkg::ST_OK;
							wr_q   <= (run_q == '0) ? CNT_W'(addr_s1) : CNT_W'(first_q);
						end
					end else begin
						run_q <= '0;
					end
				end
			end
			ffba_pkg::BS_FIND: begin
				if (scan_end) st_q <= ffba_pkg::ST_NOT_FOUND;
				else if (vld_s1 && rdata_s1 == desc_q) begin
					first_q <= addr_s1;
					last_q  <= addr_s1;
					wr_q    <= CNT_W'(addr_s1);
					st_q    <= ffba_pkg::ST_OK;
				end
			end
			ffba_pkg::BS_FIND_RUN:
				if (vld_s1 && rdata_s1 == desc_q) last_q <= addr_s1;
			ffba_pkg::BS_ADD_FILL, ffba_pkg::BS_FREE: wr_q <= wr_q + 1'b1;
			ffba_pkg::BS_DEF: if (vld_s1 && rdata_s1 != '0) wr_q <= wr_q + 1'b1;
			ffba_pkg::BS_DEF_ZERO: if (wr_q != CNT_W'(NUM_BLOCKS)) wr_q <= wr_q + 1'b1;
			default: ;
		endcase
	end

	// Map writes: one port, one entry per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::BS_CLEAR: mem[ra] <= '0;
			ffba_pkg::BS_ADD_FILL: mem[wr_q[AW-1:0]] <= desc_q;
			ffba_pkg::BS_FREE: mem[wr_q[AW-1:0]] <= '0;
			ffba_pkg::BS_DEF:
				if (vld_s1 && rdata_s1 != '0) mem[wr_q[AW-1:0]] <= rdata_s1;
			ffba_pkg::BS_DEF_ZERO:
				if (wr_q != CNT_W'(NUM_BLOCKS)) mem[wr_q[AW-1:0]] <= '0;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffba_pkg::BS_DEF |-> wr_q <= rd_q)
		else $error("defrag write pointer overtook read pointer");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than a cycle");
	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && st_q == ffba_pkg::ST_OK |-> first_q <= last_q)
		else $error("run end before run start");
`endif

endmodule

// ----- dv/ffba_checker.sv -----
// Checker of the first-fit block allocator: predicts each answer from the
// accepted requests and compares it with what the block returns.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  ffba_pkg::req_t req,
	input  logic           done,
	input  ffba_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending
);

	localparam int NBLK = 1024;

	logic [7:0]     owner_map [NBLK];
	ffba_pkg::rsp_t answer_q [$];

	// Work out the answer of one request and update the map copy
	function automatic ffba_pkg::rsp_t allocate(ffba_pkg::req_t r);
		ffba_pkg::rsp_t a;
		int need, run, first, last, wr;
		bit found;
		a = '0;
		first = 0;
		last = 0;
		if (ffba_pkg::op_t'(r.operation) == ffba_pkg::OP_DEFRAG) begin
			wr = 0;
			for (int i = 0; i < NBLK; i++) begin
				if (owner_map[i] != 0) begin
					owner_map[wr] = owner_map[i];
					wr++;
				end
			end
			for (int i = wr; i < NBLK; i++) owner_map[i] = 0;
			a.status = ffba_pkg::ST_OK;
			return a;
		end
		if (r.descriptor == 0 ||
			(ffba_pkg::op_t'(r.operation) == ffba_pkg::OP_ADD && r.size_bytes == 0)) begin
			a.status = ffba_pkg::ST_BAD;
			return a;
		end
		found = 0;
		if (ffba_pkg::op_t'(r.operation) == ffba_pkg::OP_ADD) begin
			need = (int'(r.size_bytes) + 7) / 8;
			run = 0;
			if (need <= NBLK) begin
				for (int i = 0; i < NBLK && !found; i++) begin
					if (owner_map[i] == 0) begin
						if (run == 0) first = i;
						run++;
						if (run == need) begin
							last = i;
							found = 1;
						end
					end else begin
						run = 0;
					end
				end
			end
			if (found) for (int k = first; k <= last; k++) owner_map[k] = r.descriptor;
			a.status = found ? ffba_pkg::ST_OK : ffba_pkg::ST_NO_SPACE;
		end else begin
			for (int i = 0; i < NBLK && !found; i++) begin
				if (owner_map[i] == r.descriptor) begin
					first = i;
					last = i;
					while (last + 1 < NBLK && owner_map[last + 1] == r.descriptor) last++;
					found = 1;
				end
			end
			if (found && ffba_pkg::op_t'(r.operation) == ffba_pkg::OP_DELETE)
				for (int k = first; k <= last; k++) owner_map[k] = 0;
			a.status = found ? ffba_pkg::ST_OK : ffba_pkg::ST_NOT_FOUND;
		end
		if (found) begin
			a.start_block = first[9:0];
			a.end_block = last[9:0];
		end
		return a;
	endfunction

	assign pending = answer_q.size();

	// Predict on accepted requests, compare on strobed answers
	always @(posedge clk or negedge arst_n) begin
		ffba_pkg::rsp_t exp_rsp;
		if (!arst_n) begin
			for (int i = 0; i < NBLK; i++) owner_map[i] = 0;
			answer_q.delete();
			fail_count <= 0;
		end else begin
			if (done) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected answer %h", $time, rsp);
					fail_count <= fail_count + 1;
				end else begin
					exp_rsp = answer_q.pop_front();
					if (exp_rsp.status !== rsp.status ||
						exp_rsp.start_block !== rsp.start_block ||
						exp_rsp.end_block !== rsp.end_block) begin
						$display("%0t: expected st %0d blk %0d..%0d, got st %0d blk %0d..%0d",
							$time, exp_rsp.status, exp_rsp.start_block, exp_rsp.end_block,
							rsp.status, rsp.start_block, rsp.end_block);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) answer_q.push_back(allocate(req));
		end
	end
endmodule

// ----- dv/tb.sv -----
// Testbench top of the first-fit block allocator: drives requests in bursts
// and gives the verdict. Depends on ffba_pkg, ffba_checker and the block.
`timescale 1ns / 1ps
module tb;

	localparam int IDLE_LIMIT = 40000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	ffba_pkg::req_t req = '0;
	ffba_pkg::rsp_t rsp;
	int   fail_count, pending;
	int   idle_cycles = 0;
	byte  live_desc [$];

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	first_fit_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	ffba_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	// Watchdog: count cycles with no accepted item or answer
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Hold one request until accepted, then drop start
	task automatic issue(ffba_pkg::op_t op, logic [7:0] d, logic [13:0] sz);
		@(negedge clk);
		start <= 1;
		req <= '{operation: op, descriptor: d, size_bytes: sz};
		do @(posedge clk); while (busy);
		@(negedge clk);
		start <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
	endtask

	// Mostly sizes of a few blocks, sometimes large or oversize
	function automatic logic [13:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 0;
		if (r < 75) return 14'($urandom_range(1, 200));
		if (r < 95) return 14'($urandom_range(201, 2000));
		return 14'($urandom_range(2001, 16383));
	endfunction

	task automatic random_item();
		int r;
		logic [7:0] d;
		r = $urandom_range(0, 99);
		if (live_desc.size() != 0 && $urandom_range(0, 3) != 0)
			d = live_desc[$urandom_range(0, live_desc.size() - 1)];
		else
			d = 8'($urandom_range(0, 255));
		if (r < 45) begin
			if (d != 0) live_desc.push_back(d);
			issue(ffba_pkg::OP_ADD, d, pick_size());
		end else if (r < 65) begin
			issue(ffba_pkg::OP_GET, d, 14'($urandom));
		end else if (r < 92) begin
			issue(ffba_pkg::OP_DELETE, d, 14'($urandom));
		end else begin
			issue(ffba_pkg::OP_DEFRAG, 8'($urandom), 14'($urandom));
		end
		if (live_desc.size() > 40) live_desc.delete(0);
	endtask

	initial begin
		int burst;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, each operation and each special case
		issue(ffba_pkg::OP_GET, 8'd5, 14'd0);
		issue(ffba_pkg::OP_DELETE, 8'd5, 14'd0);
		issue(ffba_pkg::OP_ADD, 8'd0, 14'd8);
		issue(ffba_pkg::OP_ADD, 8'd9, 14'd0);
		issue(ffba_pkg::OP_GET, 8'd0, 14'd0);
		issue(ffba_pkg::OP_ADD, 8'd1, 14'd1);
		issue(ffba_pkg::OP_ADD, 8'd2, 14'd8);
		issue(ffba_pkg::OP_ADD, 8'd3, 14'd9);
		issue(ffba_pkg::OP_ADD, 8'd255, 14'd8192);
		issue(ffba_pkg::OP_ADD, 8'd170, 14'd8193);
		issue(ffba_pkg::OP_ADD, 8'd85, 14'h3FFF);
		issue(ffba_pkg::OP_ADD, 8'd2, 14'd16);
		issue(ffba_pkg::OP_GET, 8'd2, 14'h3FFF);
		issue(ffba_pkg::OP_DELETE, 8'd2, 14'd0);
		issue(ffba_pkg::OP_GET, 8'd2, 14'd0);
		issue(ffba_pkg::OP_DELETE, 8'd1, 14'd0);
		issue(ffba_pkg::OP_DEFRAG, 8'd255, 14'h3FFF);
		issue(ffba_pkg::OP_GET, 8'd3, 14'd0);
		issue(ffba_pkg::OP_ADD, 8'd4, 14'd8000);
		issue(ffba_pkg::OP_ADD, 8'd6, 14'd100);
		issue(ffba_pkg::OP_DEFRAG, 8'd0, 14'd0);
		issue(ffba_pkg::OP_GET, 8'd6, 14'd0);
		issue(ffba_pkg::OP_DELETE, 8'd4, 14'd0);
		issue(ffba_pkg::OP_DELETE, 8'd3, 14'd0);
		issue(ffba_pkg::OP_DELETE, 8'd6, 14'd0);
		drain();
		// random: bursts with gaps, full pauses near the middle
		for (int n = 0; n < 265; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < 265; b++, n++) random_item();
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(posedge clk);
			if (n > 130 && n < 145) drain();
		end
		drain();
		repeat (4200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
src/ffba_pkg.sv
src/ffba_front.sv
src/ffba_back.sv
src/first_fit_block_allocator.sv
dv/ffba_checker.sv
dv/tb.sv
